// ----- hdl/vvts_pkg.sv -----
// ----------------------------------------------------------------------------
// vvts_pkg
// Shared constants, types and arithmetic helpers of the trilinear sampler.
// ----------------------------------------------------------------------------
package vvts_pkg;

  localparam int MAX_DIM     = 32;
  localparam int FRAC_BITS   = 16;
  localparam int CELL_W      = $clog2(MAX_DIM);
  localparam int SIZE_W      = CELL_W + 1;
  localparam int IDX_W       = 3 * CELL_W;
  localparam int SLICE_W     = 2 * CELL_W + 1;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int W_W         = FRAC_BITS + 1;
  localparam int PROD_W      = 33 + W_W + 1;
  localparam int SUM_W       = PROD_W + 1;
  localparam int CFG_W       = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = 208;
  localparam int OUT_DATA_W  = 96;

  localparam logic [W_W-1:0]    ONE_W   = W_W'(1) << FRAC_BITS;
  localparam logic [SIZE_W-1:0] MIN_SZ  = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] MAX_SZ  = SIZE_W'(MAX_DIM);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_SIZE = 2'd0,
    REG_Y_SIZE = 2'd1,
    REG_Z_SIZE = 2'd2,
    REG_NONE   = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_e;

  typedef struct packed {
    logic              outside;
    logic [CELL_W-1:0] cell_idx;
    logic [W_W-1:0]    w;
  } axis_t;

  function automatic logic [SIZE_W-1:0] eff_size(logic [CFG_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = SIZE_W'(v);
    if (r < MIN_SZ) r = MIN_SZ;
    else if (r > MAX_SZ) r = MAX_SZ;
    return r;
  endfunction

  function automatic axis_t axis_dec(logic signed [31:0] p, logic [SIZE_W-1:0] sz);
    axis_t       r;
    logic [14:0] ip;
    logic [15:0] fr;
    logic [14:0] cl;
    logic [14:0] top;
    ip  = p[30:16];
    fr  = p[15:0];
    top = 15'(sz) - 15'd1;
    cl  = (fr != 16'd0) ? ip : ip - 15'd1;
    r.w = (fr != 16'd0) ? {1'b0, fr} : ONE_W;
    r.outside = p[31] || (p == 32'sd0) || (cl > top);
    if (ip >= top) r.cell_idx = CELL_W'(sz - SIZE_W'(2));
    else r.cell_idx = cl[CELL_W-1:0];
    return r;
  endfunction

  // (b - a) * w, full width
  function automatic logic signed [PROD_W-1:0] dmul(logic signed [31:0] a,
                                                     logic signed [31:0] b,
                                                     logic [W_W-1:0] w);
    logic signed [32:0] d;
    d = {b[31], b} - {a[31], a};
    return PROD_W'(d) * PROD_W'($signed({1'b0, w}));
  endfunction

  // a + floor((p + half) / 2^FRAC_BITS), saturated to 32 bits
  function automatic logic signed [31:0] lfin(logic signed [31:0] a,
                                              logic signed [PROD_W-1:0] p);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(1 << (FRAC_BITS - 1));
    s = s >>> FRAC_BITS;
    s = s + SUM_W'(a);
    if (s > SUM_W'(32'sh7fffffff)) return 32'sh7fffffff;
    if (s < -SUM_W'(33'sh80000000)) return 32'sh80000000;
    return s[31:0];
  endfunction

endpackage

// ----- hdl/volume_vector_trilinear_sampler.sv -----
// ----------------------------------------------------------------------------
// volume_vector_trilinear_sampler
// Grid of 3D vectors in one synchronous memory, sampled by trilinear
// interpolation of the eight corners of the cell around a point.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake            Payload
// s_axis    in   tvalid/tready        tuser: action; tdata: index, write, point
// m_axis    out  tvalid/tready        tuser: outside; tdata: vec_x, vec_y, vec_z
// cfg       in   cfg_we_i (no wait)   cfg_idx_i, cfg_wdata_i: grid sizes
//
// A sample inside the grid reads the eight corners from the single grid memory
// read port, one per cycle while the pipeline is not frozen. After the last
// corner read the result passes stages A, B and C and the output register.
// Reset clears control state only; the grid holds no valid bits.
// A stalled output fills a skid register, then freezes the whole pipeline.
// ----------------------------------------------------------------------------
module volume_vector_trilinear_sampler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vvts_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vvts_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // voxel_index, write_x, write_y, write_z, point_x, point_y, point_z, pad
  input  logic [vvts_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // action
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // vec_x, vec_y, vec_z
  output logic [vvts_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // outside
  output logic                              m_axis_tuser
);
  import vvts_pkg::*;

  // Configuration registers
  logic [CFG_W-1:0] xs_q, ys_q, zs_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xs_q <= CFG_W'(MAX_DIM);
      ys_q <= CFG_W'(MAX_DIM);
      zs_q <= CFG_W'(MAX_DIM);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_X_SIZE: xs_q <= cfg_wdata_i;
        REG_Y_SIZE: ys_q <= cfg_wdata_i;
        REG_Z_SIZE: zs_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input fields
  logic [IDX_W-1:0]   in_vi;
  logic signed [31:0] in_wx, in_wy, in_wz, in_px, in_py, in_pz;
  assign in_vi = s_axis_tdata[14:0];
  assign in_wx = s_axis_tdata[46:15];
  assign in_wy = s_axis_tdata[78:47];
  assign in_wz = s_axis_tdata[110:79];
  assign in_px = s_axis_tdata[142:111];
  assign in_py = s_axis_tdata[174:143];
  assign in_pz = s_axis_tdata[206:175];

  // Advance: the whole pipeline moves while the skid register is empty
  logic adv;
  logic skid_v_q;
  assign adv = !skid_v_q;

  // Decode of a sample point
  logic [SIZE_W-1:0]  sx, sy, sz;
  logic [SLICE_W-1:0] slice;
  axis_t              ax, ay, az;
  logic [IDX_W-1:0]   base;
  assign sx    = eff_size(xs_q);
  assign sy    = eff_size(ys_q);
  assign sz    = eff_size(zs_q);
  assign slice = SLICE_W'(sx) * SLICE_W'(sy);
  assign ax    = axis_dec(in_px, sx);
  assign ay    = axis_dec(in_py, sy);
  assign az    = axis_dec(in_pz, sz);
  assign base  = IDX_W'(az.cell_idx) * IDX_W'(slice) + IDX_W'(ay.cell_idx) * IDX_W'(sx)
               + IDX_W'(ax.cell_idx);

  // Front end: issue the corner reads of one sample
  logic               f_busy_q, f_out_q;
  logic [2:0]         f_cnt_q;
  logic [IDX_W-1:0]   f_base_q;
  logic [SIZE_W-1:0]  f_sx_q;
  logic [SLICE_W-1:0] f_slice_q;
  logic [W_W-1:0]     f_wx_q, f_wy_q, f_wz_q;
  logic               f_last, in_acc;
  logic [IDX_W-1:0]   rd_addr;

  assign f_last        = f_out_q || (f_cnt_q == 3'd7);
  assign s_axis_tready = adv && (!f_busy_q || f_last);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign rd_addr = f_base_q + (f_cnt_q[0] ? IDX_W'(1) : IDX_W'(0))
                 + (f_cnt_q[1] ? IDX_W'(f_sx_q) : IDX_W'(0))
                 + (f_cnt_q[2] ? IDX_W'(f_slice_q) : IDX_W'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_busy_q <= 1'b0;
      f_out_q  <= 1'b0;
      f_cnt_q  <= 3'd0;
    end else if (adv) begin
      if (in_acc && action_e'(s_axis_tuser) == ACT_SAMPLE) begin
        f_busy_q <= 1'b1;
        f_out_q  <= ax.outside || ay.outside || az.outside;
        f_cnt_q  <= 3'd0;
      end else if (f_busy_q) begin
        f_busy_q <= !f_last;
        f_cnt_q  <= f_cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      f_base_q  <= base;
      f_sx_q    <= sx;
      f_slice_q <= slice;
      f_wx_q    <= ax.w;
      f_wy_q    <= ay.w;
      f_wz_q    <= az.w;
    end
  end

  // Grid memory: x, y, z components side by side
  logic [95:0] mem [STORE_DEPTH];
  logic [95:0] rd_q;
  always_ff @(posedge clk_i) begin
    if (in_acc && action_e'(s_axis_tuser) == ACT_WRITE) begin
      mem[in_vi] <= {in_wz, in_wy, in_wx};
    end
    if (adv && f_busy_q && !f_out_q) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Read stage tags
  logic           r_v_q, r_out_q;
  logic [2:0]     r_k_q;
  logic [W_W-1:0] r_wx_q, r_wy_q, r_wz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q <= 1'b0;
    end else if (adv) begin
      r_v_q <= f_busy_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_out_q <= f_out_q;
      r_k_q   <= f_cnt_q;
      r_wx_q  <= f_wx_q;
      r_wy_q  <= f_wy_q;
      r_wz_q  <= f_wz_q;
    end
  end

  // Corner collection; the eighth corner is taken straight from the memory
  logic [95:0] cn_q [7];
  logic [95:0] cur [8];
  logic        launch;
  assign launch = r_v_q && (r_out_q || r_k_q == 3'd7);
  always_ff @(posedge clk_i) begin
    if (adv && r_v_q && !r_out_q && r_k_q != 3'd7) begin
      cn_q[r_k_q] <= rd_q;
    end
  end
  always_comb begin
    for (int k = 0; k < 7; k++) cur[k] = cn_q[k];
    cur[7] = rd_q;
  end

  // Stage A: products along x
  logic                     a_v_q, a_out_q;
  logic signed [31:0]       a_lo_q [3][4];
  logic signed [PROD_W-1:0] a_p_q  [3][4];
  logic [W_W-1:0]           a_wy_q, a_wz_q;
  // Stage B: edges, products along y
  logic                     b_v_q, b_out_q;
  logic signed [31:0]       b_lo_q [3][2];
  logic signed [PROD_W-1:0] b_p_q  [3][2];
  logic [W_W-1:0]           b_wz_q;
  // Stage C: faces, product along z
  logic                     c_v_q, c_out_q;
  logic signed [31:0]       c_lo_q [3];
  logic signed [PROD_W-1:0] c_p_q  [3];

  logic signed [31:0] e_val [3][4];
  logic signed [31:0] f_val [3][2];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 4; j++) e_val[c][j] = lfin(a_lo_q[c][j], a_p_q[c][j]);
      for (int j = 0; j < 2; j++) f_val[c][j] = lfin(b_lo_q[c][j], b_p_q[c][j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= launch;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_out_q <= r_out_q;
      a_wy_q  <= r_wy_q;
      a_wz_q  <= r_wz_q;
      b_out_q <= a_out_q;
      b_wz_q  <= a_wz_q;
      c_out_q <= b_out_q;
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 4; j++) begin
          a_lo_q[c][j] <= cur[2*j][32*c +: 32];
          a_p_q[c][j]  <= dmul(cur[2*j][32*c +: 32], cur[2*j+1][32*c +: 32], r_wx_q);
        end
        for (int j = 0; j < 2; j++) begin
          b_lo_q[c][j] <= e_val[c][2*j];
          b_p_q[c][j]  <= dmul(e_val[c][2*j], e_val[c][2*j+1], a_wy_q);
        end
        c_lo_q[c] <= f_val[c][0];
        c_p_q[c]  <= dmul(f_val[c][0], f_val[c][1], b_wz_q);
      end
    end
  end

  // Stage D: final lerp along z, then output register and skid
  logic [95:0] d_data;
  logic        push, pop;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d_data[32*c +: 32] = c_out_q ? 32'd0 : lfin(c_lo_q[c], c_p_q[c]);
    end
  end
  assign push = adv && c_v_q;
  assign pop  = m_axis_tvalid && m_axis_tready;

  logic        out_v_q, out_u_q, skid_u_q;
  logic [95:0] out_q, skid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || pop) begin
      out_v_q  <= skid_v_q || push;
      skid_v_q <= 1'b0;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (!out_v_q || pop) begin
      out_q   <= skid_v_q ? skid_q : d_data;
      out_u_q <= skid_v_q ? skid_u_q : c_out_q;
    end else if (push) begin
      skid_q   <= d_data;
      skid_u_q <= c_out_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = out_u_q;

endmodule

// ----- bench/vvts_checker.sv -----
// ----------------------------------------------------------------------------
// vvts_checker
// Watches the config port and both streams of the trilinear sampler, keeps a
// shadow grid, predicts each sample result and compares it field by field.
// ----------------------------------------------------------------------------
module vvts_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vvts_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vvts_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [vvts_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [vvts_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              m_axis_tuser,
  output int                                fail_count_o,
  output int                                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import vvts_pkg::*;

  typedef struct {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic               outside;
  } sample_result_t;

  logic [31:0]    grid_x [STORE_DEPTH];
  logic [31:0]    grid_y [STORE_DEPTH];
  logic [31:0]    grid_z [STORE_DEPTH];
  logic [CFG_W-1:0] size_reg [3];
  sample_result_t expected_samples [$];
  int             fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_samples.size();

  function automatic longint clamp_size(logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_DIM) return MAX_DIM;
    return longint'(v);
  endfunction

  // Map one coordinate to a cell and a weight; return 0 when outside.
  function automatic bit map_axis(logic signed [31:0] p, longint sz,
                                  output longint cell_idx, output longint w);
    longint pv;
    longint fr;
    pv = longint'(p);
    cell_idx = 0;
    w = 0;
    if (pv <= 0) return 0;
    fr = pv & ((64'sd1 << FRAC_BITS) - 1);
    if (fr != 0) begin
      cell_idx = pv >>> FRAC_BITS;
      w = fr;
    end else begin
      cell_idx = (pv >>> FRAC_BITS) - 1;
      w = 64'sd1 << FRAC_BITS;
    end
    if (cell_idx > sz - 1) return 0;
    // hold the weight, pull the cell back to the last full one
    if (pv > (((sz - 1) <<< FRAC_BITS) - 1)) cell_idx = sz - 2;
    return 1;
  endfunction

  function automatic longint blend(longint a, longint b, longint w);
    return a + (((b - a) * w + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] saturate32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic sample_result_t predict_sample(logic signed [31:0] px,
                                                    logic signed [31:0] py,
                                                    logic signed [31:0] pz);
    sample_result_t r;
    longint sx, sy, sz, cx, cy, cz, wx, wy, wz, slice, base;
    longint v [8];
    longint e [4];
    int     idx [8];
    bit     in_x, in_y, in_z;
    sx = clamp_size(size_reg[REG_X_SIZE]);
    sy = clamp_size(size_reg[REG_Y_SIZE]);
    sz = clamp_size(size_reg[REG_Z_SIZE]);
    r = '{0, 0, 0, 1'b1};
    in_x = map_axis(px, sx, cx, wx);
    in_y = map_axis(py, sy, cy, wy);
    in_z = map_axis(pz, sz, cz, wz);
    if (!(in_x && in_y && in_z)) return r;
    slice = sx * sy;
    base = cz * slice + cy * sx + cx;
    // corners ordered x fastest, then y, then z
    for (int k = 0; k < 8; k++) begin
      idx[k] = int'(base + ((k & 1) ? 1 : 0) + ((k & 2) ? sx : 0) + ((k & 4) ? slice : 0));
      if (idx[k] >= STORE_DEPTH) idx[k] = 0;
    end
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 8; k++) begin
        case (c)
          0: v[k] = longint'($signed(grid_x[idx[k]]));
          1: v[k] = longint'($signed(grid_y[idx[k]]));
          default: v[k] = longint'($signed(grid_z[idx[k]]));
        endcase
      end
      for (int k = 0; k < 4; k++) e[k] = blend(v[2*k], v[2*k+1], wx);
      case (c)
        0: r.vx = saturate32(blend(blend(e[0], e[1], wy), blend(e[2], e[3], wy), wz));
        1: r.vy = saturate32(blend(blend(e[0], e[1], wy), blend(e[2], e[3], wy), wz));
        default: r.vz = saturate32(blend(blend(e[0], e[1], wy), blend(e[2], e[3], wy), wz));
      endcase
    end
    r.outside = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_result_t exp_r;
    sample_result_t got_r;
    logic [14:0]    vidx;
    if (!rst_ni) begin
      size_reg[0] = 6'd32;
      size_reg[1] = 6'd32;
      size_reg[2] = 6'd32;
      expected_samples.delete();
      fail_count = 0;
    end else begin
      if (cfg_we_i && cfg_idx_i != REG_NONE) size_reg[cfg_idx_i] = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        if (action_e'(s_axis_tuser) == ACT_WRITE) begin
          vidx = s_axis_tdata[14:0];
          grid_x[vidx] = s_axis_tdata[46:15];
          grid_y[vidx] = s_axis_tdata[78:47];
          grid_z[vidx] = s_axis_tdata[110:79];
        end else begin
          expected_samples.push_back(predict_sample(s_axis_tdata[142:111],
                                                    s_axis_tdata[174:143],
                                                    s_axis_tdata[206:175]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_r = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                  m_axis_tuser};
        if (expected_samples.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result transfer with nothing expected: %h %h %h out=%b",
                     got_r.vx, got_r.vy, got_r.vz, got_r.outside);
        end else begin
          exp_r = expected_samples.pop_front();
          if (got_r.vx !== exp_r.vx || got_r.vy !== exp_r.vy ||
              got_r.vz !== exp_r.vz || got_r.outside !== exp_r.outside) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp %h %h %h out=%b, got %h %h %h out=%b",
                       exp_r.vx, exp_r.vy, exp_r.vz, exp_r.outside,
                       got_r.vx, got_r.vy, got_r.vz, got_r.outside);
          end
        end
      end
    end
  end

endmodule

// ----- bench/tb_volume_vector_trilinear_sampler.sv -----
// ----------------------------------------------------------------------------
// tb_volume_vector_trilinear_sampler
// Stimulus for the trilinear sampler: several grid sizes, each filled
// completely, then directed and random writes and samples under random
// stalls on both streams. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_volume_vector_trilinear_sampler;
  timeunit 1ns;
  timeprecision 1ps;
  import vvts_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 32;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = REG_X_SIZE;
  logic [CFG_W-1:0]       cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   m_axis_tuser;
  int                     fail_count;
  int                     pending;
  int                     cycle_count = 0;
  int                     hold_left = 0;
  bit                     no_idle = 1'b0;
  bit                     hold_go = 1'b0;
  bit                     hold_done = 1'b0;
  int                     cur_sx, cur_sy, cur_sz;

  volume_vector_trilinear_sampler u_dut (.*);

  vvts_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Timeout: end the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Long receiver hold-off, once, at the start of a long random run: the
  // block must fill up and stall its input while the sender keeps offering.
  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    else if (!hold_done && hold_go) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  // Receiver side: drop ready at random, hold it low during the hold-off.
  always @(posedge clk_i) begin
    if (hold_left > 0) m_axis_tready <= 1'b0;
    else m_axis_tready <= no_idle || ($urandom_range(99) >= 33);
  end

  function automatic logic [IN_DATA_W-1:0] pack_item(logic [14:0] vidx,
      logic [31:0] wx, logic [31:0] wy, logic [31:0] wz,
      logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    return {1'b0, pz, py, px, wz, wy, wx, vidx};
  endfunction

  // Offer one item and hold it until the transfer; idle before it at random.
  task automatic send_item(action_e act, logic [IN_DATA_W-1:0] data);
    while (!no_idle && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_write(logic [14:0] vidx, logic [31:0] wx, logic [31:0] wy,
                            logic [31:0] wz);
    send_item(ACT_WRITE, pack_item(vidx, wx, wy, wz, $urandom, $urandom, $urandom));
  endtask

  task automatic send_sample(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    send_item(ACT_SAMPLE, pack_item(15'($urandom), $urandom, $urandom, $urandom,
                                    px, py, pz));
  endtask

  // Wait for every result, then let the pipeline settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_size(cfg_reg_e r, logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic int eff(logic [CFG_W-1:0] v);
    return (v < 2) ? 2 : (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  // Pick a coordinate: mostly inside, plus integers, the top edge and noise.
  function automatic logic [31:0] pick_coord(int sz);
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return $urandom_range((sz << 16) + 32'h8000, 1);
    if (sel < 67) return $urandom_range(sz) << 16;
    if (sel < 79) return ((sz - 1) << 16) + $urandom_range(4) - 2;
    if (sel < 90) return $urandom;
    return -$urandom_range(32'h30000);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(32'h3ffff) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  logic [CFG_W-1:0] size_plan [8][3] = '{
    '{6'd4, 6'd4, 6'd4}, '{6'd2, 6'd3, 6'd5}, '{6'd0, 6'd1, 6'd63},
    '{6'd32, 6'd2, 6'd2}, '{6'd2, 6'd32, 6'd2}, '{6'd5, 6'd7, 6'd3},
    '{6'd3, 6'd3, 6'd3}, '{6'd1, 6'd6, 6'd4}
  };

  initial begin
    int vol;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_size(REG_NONE, 6'd17);
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      write_size(REG_X_SIZE, size_plan[ph][0]);
      write_size(REG_Y_SIZE, size_plan[ph][1]);
      write_size(REG_Z_SIZE, size_plan[ph][2]);
      cur_sx = eff(size_plan[ph][0]);
      cur_sy = eff(size_plan[ph][1]);
      cur_sz = eff(size_plan[ph][2]);
      vol = cur_sx * cur_sy * cur_sz;
      // one phase runs with no idling on either side
      no_idle = (ph == 3);
      // fill every grid point in use so no sample reads an unwritten entry
      for (int i = 0; i < vol; i++) send_write(15'(i), pick_value(), pick_value(),
                                               pick_value());
      if (ph == 0) begin
        send_write(15'h7fff, 32'h7fffffff, 32'h80000000, 32'h0);
        send_write(15'h0, 32'h80000000, 32'h7fffffff, 32'hffffffff);
        send_write(15'h1, 32'h7fffffff, 32'h80000000, 32'h00010000);
        send_sample(32'h0, 32'h8000, 32'h8000);
        send_sample(32'hffffffff, 32'h8000, 32'h8000);
        send_sample(32'h80000000, 32'h8000, 32'h8000);
        send_sample(32'h7fffffff, 32'h8000, 32'h8000);
        send_sample(32'h00010000, 32'h00010000, 32'h00010000);
        send_sample(32'h00030000, 32'h00030000, 32'h00030000);
        send_sample(32'h0002ffff, 32'h0002ffff, 32'h0002ffff);
        send_sample(32'h00030001, 32'h00020001, 32'h00010001);
        send_sample(32'h00040000, 32'h00008000, 32'h00008000);
        send_sample(32'h00040001, 32'h00008000, 32'h00008000);
        send_sample(32'h00000001, 32'h0000ffff, 32'h00018000);
        send_sample(32'h00008000, 32'h00000000, 32'h00008000);
        send_sample(32'h00008000, 32'h00008000, 32'h80000000);
        send_sample(32'h00008000, 32'h7fffffff, 32'h00008000);
        send_sample(32'h00008000, 32'h00008000, 32'h00030000);
        send_sample(32'h00008000, 32'h00008000, 32'h00028000);
      end
      for (int n = 0; n < 150; n++) begin
        // start the receiver hold-off while plenty of items remain to offer
        if (ph == 4 && n == 0) hold_go = 1'b1;
        if ($urandom_range(99) < 25) begin
          if ($urandom_range(1)) send_write(15'($urandom_range(vol - 1)), pick_value(),
                                            pick_value(), pick_value());
          else send_write(15'($urandom), pick_value(), pick_value(), pick_value());
        end else begin
          send_sample(pick_coord(cur_sx), pick_coord(cur_sy), pick_coord(cur_sz));
        end
      end
    end
    wait_idle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/vvts_pkg.sv
hdl/volume_vector_trilinear_sampler.sv
bench/vvts_checker.sv
bench/tb_volume_vector_trilinear_sampler.sv
